FILE: rtl/sfb64_pkg.sv
// Shared types and constants for the status-field base64 extractor.
// Used by every RTL file of the block; depends on nothing else.
`default_nettype none

package sfb64_pkg;

    // Most result beats one character can cause: three bytes and a summary.
    localparam int RES_MAX = 4;

    // Reset value of the status_size register.
    localparam logic [7:0] STATUS_SIZE_RST = 8'd64;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       found;
        logic [7:0] byte_count;
        logic       run_end;
    } t_out;

    // All result beats produced by one character, in delivery order.
    typedef struct packed {
        logic [2:0]             cnt;
        t_out [RES_MAX-1:0]     res;
    } t_bundle;

endpackage

`default_nettype wire

FILE: rtl/sfb64_core.sv
// Marker search, base64 group assembly and group decode for one character.
// Holds the per-string state; depends on sfb64_pkg.
`default_nettype none

module sfb64_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  sfb64_pkg::t_in     i_item,
    input  logic [7:0]         i_status_size,
    output sfb64_pkg::t_bundle o_bundle
);
    import sfb64_pkg::*;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_DECODE = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Returns {valid, sextet}.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == CH_PLUS) begin
            r = {1'b1, 6'd62};
        end else if (c == CH_SLASH) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    t_phase      r_phase, n_phase;
    logic [1:0]  r_mp, n_mp;
    logic [23:0] r_bits, n_bits;
    logic [3:0]  r_pads, n_pads;
    logic [1:0]  r_fill, n_fill;
    logic [7:0]  r_emit, n_emit;
    logic        r_str_end, n_str_end;

    logic        char_ok, fin;
    logic [7:0]  c;
    logic [6:0]  sx;
    t_phase      ph_a, ph_c;
    logic [1:0]  mp_a;
    logic [23:0] bits_a, bits_p;
    logic [3:0]  pads_a, pads_p;
    logic [2:0]  fill_a, fill_p;
    logic [1:0]  nbytes, emit_n;
    logic [7:0]  room, em_c;
    logic        closing;
    t_bundle     bun;

    always_comb begin
        c       = i_item.ch;
        char_ok = !r_str_end && (c != 8'd0);
        fin     = !r_str_end && ((c == 8'd0) || i_item.last);
        sx      = sextet_of(c);

        // Effect of the character itself.
        ph_a   = r_phase;
        mp_a   = r_mp;
        bits_a = r_bits;
        pads_a = r_pads;
        fill_a = {1'b0, r_fill};
        if (char_ok) begin
            case (r_phase)
                PH_SEARCH: begin
                    case (r_mp)
                        2'd0: mp_a = (c == CH_S) ? 2'd1 : 2'd0;
                        2'd1: mp_a = (c == CH_T) ? 2'd2 : ((c == CH_S) ? 2'd1 : 2'd0);
                        2'd2: mp_a = (c == CH_S) ? 2'd3 : 2'd0;
                        default: begin
                            if (c == CH_COLON) begin
                                ph_a = PH_DECODE;
                                mp_a = 2'd0;
                            end else if (c == CH_T) begin
                                mp_a = 2'd2;
                            end else if (c == CH_S) begin
                                mp_a = 2'd1;
                            end else begin
                                mp_a = 2'd0;
                            end
                        end
                    endcase
                end
                PH_DECODE: begin
                    if (sx[6] || (c == CH_PAD)) begin
                        bits_a = {r_bits[17:0], (sx[6] ? sx[5:0] : 6'd0)};
                        pads_a = r_pads | ({3'b000, !sx[6]} << r_fill);
                        fill_a = {1'b0, r_fill} + 3'd1;
                    end
                end
                default: ;
            endcase
        end

        // At the end of the string an open group is filled up with pads.
        bits_p = bits_a;
        pads_p = pads_a;
        fill_p = fill_a;
        if (fin && (ph_a == PH_DECODE)) begin
            case (fill_a)
                3'd1: begin
                    bits_p = {bits_a[5:0], 18'd0};
                    pads_p = pads_a | 4'b1110;
                    fill_p = 3'd4;
                end
                3'd2: begin
                    bits_p = {bits_a[11:0], 12'd0};
                    pads_p = pads_a | 4'b1100;
                    fill_p = 3'd4;
                end
                3'd3: begin
                    bits_p = {bits_a[17:0], 6'd0};
                    pads_p = pads_a | 4'b1000;
                    fill_p = 3'd4;
                end
                default: ;
            endcase
        end

        // Group decision: number of bytes, room check, end of decoding.
        closing = (fill_p == 3'd4);
        ph_c    = ph_a;
        em_c    = r_emit;
        emit_n  = 2'd0;
        case (pads_p)
            4'b0000: nbytes = 2'd3;
            4'b1000: nbytes = 2'd2;
            4'b1100: nbytes = 2'd1;
            default: nbytes = 2'd0;
        endcase
        room = (r_emit < i_status_size) ? (i_status_size - r_emit) : 8'd0;
        if (closing) begin
            if ({6'd0, nbytes} <= room) begin
                emit_n = nbytes;
                em_c   = r_emit + {6'd0, nbytes};
                if (nbytes != 2'd3) begin
                    ph_c = PH_DONE;
                end
            end else begin
                ph_c = PH_DONE;
            end
        end

        // Result beats: bytes first, then the summary.
        bun = '0;
        for (int i = 0; i < RES_MAX - 1; i++) begin
            bun.res[i].data_byte = bits_p[23 - 8*i -: 8];
        end
        if (fin) begin
            bun.res[emit_n]            = '0;
            bun.res[emit_n].kind       = 1'b1;
            bun.res[emit_n].found      = (ph_c != PH_SEARCH);
            bun.res[emit_n].byte_count = em_c;
        end
        bun.cnt = {1'b0, emit_n} + {2'b00, fin};
        for (int i = 0; i < RES_MAX; i++) begin
            bun.res[i].run_end = (3'(i) == (bun.cnt - 3'd1));
        end

        // Next state.
        n_str_end = r_str_end ? !i_item.last : ((c == 8'd0) && !i_item.last);
        if (fin) begin
            n_phase = PH_SEARCH;
            n_mp    = 2'd0;
            n_bits  = 24'd0;
            n_pads  = 4'd0;
            n_fill  = 2'd0;
            n_emit  = 8'd0;
        end else begin
            n_phase = ph_c;
            n_mp    = mp_a;
            n_emit  = em_c;
            if (closing) begin
                n_bits = 24'd0;
                n_pads = 4'd0;
                n_fill = 2'd0;
            end else begin
                n_bits = bits_a;
                n_pads = pads_a;
                n_fill = fill_a[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_mp      <= 2'd0;
            r_bits    <= 24'd0;
            r_pads    <= 4'd0;
            r_fill    <= 2'd0;
            r_emit    <= 8'd0;
            r_str_end <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_mp      <= n_mp;
            r_bits    <= n_bits;
            r_pads    <= n_pads;
            r_fill    <= n_fill;
            r_emit    <= n_emit;
            r_str_end <= n_str_end;
        end
    end

    assign o_bundle = bun;

endmodule

`default_nettype wire

FILE: rtl/sfb64_outq.sv
// Result register: holds one bundle of result beats and hands them out one per beat.
// Depends on sfb64_pkg.
`default_nettype none

module sfb64_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  sfb64_pkg::t_bundle i_bundle,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output sfb64_pkg::t_out    o_out_data,
    output logic               o_can_load
);
    import sfb64_pkg::*;

    t_out [RES_MAX-1:0] r_res;
    logic [2:0]         r_cnt;
    logic [1:0]         r_idx;
    logic               pop, pop_last;

    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_res[r_idx];
    assign pop         = o_out_valid && i_out_ready;
    assign pop_last    = pop && ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign o_can_load  = !o_out_valid || pop_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
            r_idx <= 2'd0;
        end else if (pop_last) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_bundle.res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/status_field_base64_extractor.sv
// Top level of the status-field base64 extractor: input register, status_size
// register, core and result register. Depends on sfb64_pkg, sfb64_core, sfb64_outq.
`default_nettype none

// The block takes a device-ID string one character per beat, with a last flag,
// finds the first "STS:" and decodes the base64 text after it into status bytes.
// Each character beat yields zero to four result beats: decoded bytes, and at the
// end of a string (last flag or zero byte) one summary beat with the found flag
// and the byte count; run_end marks the final result beat of a character.
// A character is taken in every cycle. It passes through an input register into
// the decode logic, and the results it causes are loaded as one bundle into the
// result register, which hands them out one per cycle while i_out_ready is high.
// A character that causes results waits in the input register until the previous
// bundle hands out its final beat, which may happen in the same cycle as the
// load; characters after a closing group cause no results while its bytes go out,
// so with i_out_ready high base64 text streams at one character per cycle.
// status_size is written through i_cfg_we and i_cfg_data, takes effect at the
// next group decision, and resets to 64. Reset is synchronous and active low.

module status_field_base64_extractor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sfb64_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sfb64_pkg::t_out o_out_data,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_data
);
    import sfb64_pkg::*;

    // Input register: one character beat waiting for the decode logic.
    logic    r_in_valid;
    t_in     r_in;
    logic [7:0] r_size;

    t_bundle bundle;
    logic    can_load;
    logic    fire;
    logic    load;

    // A character with no results never waits for the result register.
    assign fire       = r_in_valid && ((bundle.cnt == 3'd0) || can_load);
    assign load       = fire && (bundle.cnt != 3'd0);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= STATUS_SIZE_RST;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    sfb64_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (r_in),
        .i_status_size (r_size),
        .o_bundle      (bundle)
    );

    sfb64_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_bundle    (bundle),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_can_load  (can_load)
    );

    // The summary is always the final result beat of its character.
    a_summary_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind) |-> o_out_data.run_end)
        else $error("summary beat without run_end");

    // Nothing leaves the block in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    // A held character stays put until the decode logic takes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in)))
        else $error("held character lost or changed");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for status_field_base64_extractor.
// Depends on sfb64_pkg and the RTL of the block; it needs no other file.
// Checks are made beat by beat against a behavioral model kept inside this file.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfb64_pkg::*;

    // Cycles allowed after the last expected beat before the block counts as idle.
    // This covers the input register, the decode stage and the result register
    // when the final characters of a phase produce no beat at all.
    localparam int DRAIN_CYCLES = 8;
    // Length of the long output hold that backs the block up into its input.
    localparam int HOLD_CYCLES = 300;

    // Scanner state of the behavioral model.
    typedef enum logic [1:0] {
        SCAN_HUNT,
        SCAN_DECODE,
        SCAN_DONE
    } t_scan;

    // Clock, reset and the block's inputs; all start at known values.
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in        in_data = '0;
    logic       out_ready = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_data = '0;

    logic       in_ready;
    logic       out_valid;
    t_out       out_data;

    // Model state: the mirror of status_size, the marker scanner, the open
    // group and the per-string byte count.
    logic [7:0]  size_reg = STATUS_SIZE_RST;
    t_scan       scan = SCAN_HUNT;
    logic [1:0]  mark_cnt = '0;
    logic [23:0] grp_bits = '0;
    logic [3:0]  grp_pads = '0;
    logic [2:0]  grp_fill = '0;
    logic [7:0]  sent_bytes = '0;
    logic        skip_rest = 1'b0;

    // Beats that the current character produces, and every beat still owed by
    // the block, oldest first.
    t_out step_res[$];
    t_out pred_beats[$];
    // Characters of the next random string, in send order.
    t_in  text_q[$];

    // Idling controls; the percentages are read by the sender and the receiver.
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    int fails = 0;
    int chars_sent = 0;
    int beats_seen = 0;
    int sizes_written = 0;

    always #5 clk = ~clk;

    status_field_base64_extractor uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Behavioral model
    // ------------------------------------------------------------------

    // Maps a base64 alphabet character to its 6-bit value, or -1 for any
    // character outside the alphabet (the pad character included).
    function automatic int sextet_val(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return c - "a" + 26;
        if (c >= "0" && c <= "9") return c - "0" + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return -1;
    endfunction

    task automatic add_beat(input logic bkind, input logic [7:0] bdata,
                            input logic bfound, input logic [7:0] bcount);
        t_out r;
        r.kind = bkind;
        r.data_byte = bdata;
        r.found = bfound;
        r.byte_count = bcount;
        r.run_end = 1'b0;
        step_res.push_back(r);
    endtask

    // A full group decides how many bytes it carries from where its pads sit.
    // Pads anywhere but at the tail, or a group that will not fit in the room
    // left by status_size, stop decoding without emitting anything.
    task automatic close_group();
        int nbytes;
        int room;
        int k;
        case (grp_pads)
            4'h0:    nbytes = 3;
            4'h8:    nbytes = 2;
            4'hC:    nbytes = 1;
            default: nbytes = 0;
        endcase
        room = (sent_bytes < size_reg) ? int'(size_reg) - int'(sent_bytes) : 0;
        if (nbytes <= room) begin
            for (k = 0; k < nbytes; k++)
                add_beat(1'b0, grp_bits[23 - 8 * k -: 8], 1'b0, 8'd0);
            sent_bytes = sent_bytes + 8'(nbytes);
            if (nbytes < 3) scan = SCAN_DONE;
        end else begin
            scan = SCAN_DONE;
        end
        grp_bits = '0;
        grp_pads = '0;
        grp_fill = '0;
    endtask

    task automatic push_sextet(input logic [5:0] val, input logic pad);
        grp_bits = {grp_bits[17:0], val};
        grp_pads[grp_fill[1:0]] = grp_pads[grp_fill[1:0]] | pad;
        grp_fill = grp_fill + 3'd1;
        if (grp_fill >= 3'd4) close_group();
    endtask

    // Marker scanner for "STS:". On a mismatch it falls back to the longest
    // prefix of the marker that still ends at the current character.
    task automatic hunt_marker(input logic [7:0] c);
        case (mark_cnt)
            2'd0: mark_cnt = (c == "S") ? 2'd1 : 2'd0;
            2'd1: mark_cnt = (c == "T") ? 2'd2 : (c == "S") ? 2'd1 : 2'd0;
            2'd2: mark_cnt = (c == "S") ? 2'd3 : 2'd0;
            default: begin
                if (c == ":") begin
                    scan = SCAN_DECODE;
                    mark_cnt = 2'd0;
                end else if (c == "T") begin
                    mark_cnt = 2'd2;
                end else if (c == "S") begin
                    mark_cnt = 2'd1;
                end else begin
                    mark_cnt = 2'd0;
                end
            end
        endcase
    endtask

    // End of a string: an open group is filled up with pads and decoded, then
    // the summary beat goes out and everything is cleared for the next string.
    task automatic close_string();
        if (scan == SCAN_DECODE)
            while (grp_fill != 3'd0) push_sextet(6'd0, 1'b1);
        add_beat(1'b1, 8'd0, scan != SCAN_HUNT, sent_bytes);
        scan = SCAN_HUNT;
        mark_cnt = '0;
        grp_bits = '0;
        grp_pads = '0;
        grp_fill = '0;
        sent_bytes = '0;
    endtask

    // Works out every beat that one accepted character causes and queues them.
    task automatic decode_char(input t_in it);
        int v;
        t_out r;
        step_res.delete();
        if (skip_rest) begin
            // After a zero byte, characters are dropped up to the last flag.
            if (it.last) skip_rest = 1'b0;
            return;
        end
        if (it.ch == 8'h00) begin
            close_string();
            skip_rest = !it.last;
        end else begin
            if (scan == SCAN_HUNT) begin
                hunt_marker(it.ch);
            end else if (scan == SCAN_DECODE) begin
                v = sextet_val(it.ch);
                if (v >= 0) push_sextet(v[5:0], 1'b0);
                else if (it.ch == "=") push_sextet(6'd0, 1'b1);
            end
            if (it.last) close_string();
        end
        if (step_res.size() > 0) begin
            r = step_res.pop_back();
            r.run_end = 1'b1;
            step_res.push_back(r);
        end
        foreach (step_res[i]) pred_beats.push_back(step_res[i]);
    endtask

    // ------------------------------------------------------------------
    // Result side: receiver stalls, the long hold and the beat checker
    // ------------------------------------------------------------------

    // The hold counter runs in its own process; a test asks for a hold by
    // bumping hold_req, and the counter acknowledges it when it starts.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack <= hold_req;
        end
    end

    always @(posedge clk) begin
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Every accepted output beat is compared with the oldest predicted beat.
    always @(posedge clk) begin : beat_check
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pred_beats.size() == 0) begin
                $error("result beat with nothing predicted: kind %0d data %0d count %0d",
                       out_data.kind, out_data.data_byte, out_data.byte_count);
                fails++;
            end else begin
                want = pred_beats.pop_front();
                check_field("kind", want.kind, out_data.kind);
                check_field("data_byte", want.data_byte, out_data.data_byte);
                check_field("found", want.found, out_data.found);
                check_field("byte_count", want.byte_count, out_data.byte_count);
                check_field("run_end", want.run_end, out_data.run_end);
                beats_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one character beat and returns at the edge where it is taken.
    // Valid is left high on return, so a following call in the same time
    // step simply swaps in the next payload; a gap drops it first.
    task automatic send_char(input t_in it);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        decode_char(it);
        chars_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic lst);
        t_in it;
        it.ch = c;
        it.last = lst;
        send_char(it);
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // Stops offering characters and waits until every predicted beat has
    // come out, plus a margin for characters that produce nothing.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pred_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes status_size; only called while the block is idle.
    task automatic set_size(input logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_reg = v;
        sizes_written++;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random strings
    // ------------------------------------------------------------------

    function automatic logic [7:0] b64_char(input int v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? "+" : "/";
    endfunction

    // Characters that tend to disturb the marker scanner, plus arbitrary bytes.
    function automatic logic [7:0] noise_ch();
        case ($urandom_range(9))
            0: return "S";
            1: return "T";
            2: return ":";
            3: return "=";
            4: return b64_char($urandom_range(63));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Characters outside the alphabet, which the decoder skips.
    function automatic logic [7:0] sep_ch();
        case ($urandom_range(4))
            0: return ",";
            1: return " ";
            2: return "-";
            3: return ";";
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    task automatic put_ch(input logic [7:0] c, input logic lst);
        t_in it;
        it.ch = c;
        it.last = lst;
        text_q.push_back(it);
    endtask

    // Builds one string: noise, usually the marker, groups of base64 text
    // with random content and pad layouts, separators, an optional open tail
    // and one of the ways a string can end.
    task automatic build_string();
        int r;
        int g;
        int p;
        int style;
        int bad_pos;
        logic pad;
        t_in it;
        text_q.delete();
        repeat ($urandom_range(0, 6)) put_ch(noise_ch(), 1'b0);
        if ($urandom_range(99) < 85) begin
            put_ch("S", 1'b0);
            put_ch("T", 1'b0);
            put_ch("S", 1'b0);
            put_ch(":", 1'b0);
        end
        for (g = $urandom_range(0, 5); g > 0; g--) begin
            style = $urandom_range(99);
            bad_pos = $urandom_range(0, 2);
            for (p = 0; p < 4; p++) begin
                if (style < 70)      pad = 1'b0;
                else if (style < 80) pad = (p == 3);
                else if (style < 88) pad = (p >= 2);
                else if (style < 95) pad = (p == bad_pos);
                else                 pad = 1'b1;
                if ($urandom_range(99) < 12) put_ch(sep_ch(), 1'b0);
                put_ch(pad ? 8'("=") : b64_char($urandom_range(63)), 1'b0);
            end
        end
        if ($urandom_range(99) < 35)
            repeat ($urandom_range(1, 3)) put_ch(b64_char($urandom_range(63)), 1'b0);
        r = $urandom_range(99);
        if (r < 80) begin
            if (text_q.size() == 0) put_ch(b64_char($urandom_range(63)), 1'b0);
            it = text_q.pop_back();
            it.last = 1'b1;
            text_q.push_back(it);
        end else if (r < 90) begin
            put_ch(8'h00, 1'b1);
        end else begin
            // Zero byte before the last flag: the rest up to it is dropped.
            put_ch(8'h00, 1'b0);
            repeat ($urandom_range(0, 3)) put_ch(8'($urandom_range(0, 255)), 1'b0);
            put_ch(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    function automatic logic [7:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 8'($urandom_range(0, 12));
        if (r < 60) return 8'd255;
        if (r < 70) return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends whole random strings until about n characters have gone in. Now
    // and then, between strings, status_size is rewritten while idle.
    task automatic random_strings(input int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(5) == 0) begin
                wait_drained();
                set_size(pick_size());
            end
            build_string();
            foreach (text_q[i]) send_char(text_q[i]);
            sent += text_q.size();
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Overlapping partial markers need the scanner to fall back; the marker
    // completes on the final character, so found is set with no bytes.
    task automatic test_marker_fallback();
        send_text("aSSTSTS:", 1'b1);
    endtask

    // Two bytes from a group with one trailing pad, the top alphabet values,
    // and decoding stopped after the short group; the closing character has
    // its top bit set and is ignored.
    task automatic test_pad_and_high_bit();
        send_text("STS:/+9=", 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // A zero byte closes the string at once and the rest is dropped through
    // the last flag; then a zero byte that carries the last flag itself.
    task automatic test_zero_byte();
        send_byte("S", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte("A", 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    // A full group, then an open group of two characters padded at the end.
    task automatic test_open_group();
        send_text("STS:Zm9vYQ", 1'b1);
    endtask

    // status_size at zero overruns on the first group; then a write between
    // groups that drops the limit below what was already emitted.
    task automatic test_status_size();
        wait_drained();
        set_size(8'd0);
        send_text("STS:QUJD", 1'b1);
        wait_drained();
        set_size(8'd255);
        send_text("STS:QUJD", 1'b0);
        wait_drained();
        set_size(8'd2);
        send_text("RUZH.", 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random phases
    // ------------------------------------------------------------------

    // Full rate on both sides, with one long hold on the output so that the
    // block backs up and stops taking characters.
    task automatic test_no_idle();
        wait_drained();
        gap_pct = 0;
        stall_pct = 0;
        set_size(8'd255);
        hold_req <= hold_req + 1;
        random_strings(100);
    endtask

    task automatic test_sender_gaps();
        wait_drained();
        gap_pct = 72;
        stall_pct = 0;
        set_size(8'($urandom_range(1, 12)));
        random_strings(100);
    endtask

    task automatic test_receiver_stalls();
        wait_drained();
        gap_pct = 0;
        stall_pct = 72;
        set_size(STATUS_SIZE_RST);
        random_strings(100);
    endtask

    task automatic test_both_idle();
        wait_drained();
        gap_pct = 18;
        stall_pct = 18;
        set_size(8'($urandom_range(0, 255)));
        random_strings(100);
    endtask

    // ------------------------------------------------------------------
    // Sequence and end of run
    // ------------------------------------------------------------------

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_marker_fallback();
        test_pad_and_high_bit();
        test_zero_byte();
        test_open_group();
        test_status_size();
        test_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        wait_drained();
        if (pred_beats.size() != 0) begin
            $error("%0d predicted beats never arrived", pred_beats.size());
            fails++;
        end
        $display("Run covered %0d characters and %0d checked result beats,",
                 chars_sent, beats_seen);
        $display("with %0d status_size writes and one long output hold.", sizes_written);
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Guard against a hang; far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
